/* rtl/plcr_pkg.sv */
// shared types, constants and helpers of the color ramp
package plcr_pkg;

  localparam int CH_W          = 17;
  localparam int Q_W           = 17;
  localparam int FRAC_W        = 16;
  localparam int IDX_W         = 12;
  localparam int SIZE_W        = 13;
  localparam int CNT_W         = 5;
  localparam int NIDX_W        = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 13;
  localparam int INFLIGHT_W    = 7;
  localparam int MAX_NODES_DEF = 16;
  localparam int MAX_TEXELS    = 4096;

  localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(65536);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TEXEL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXTURE_SIZE = 2'd0,
    REG_USED_NODES   = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } color_t;

  typedef struct packed {
    color_t         color;
    logic [Q_W-1:0] pos;
  } node_t;

  // side data carried through the weight divider
  typedef struct packed {
    logic   empty;
    logic   al_zero;
    logic   al_one;
    color_t left;
    color_t right;
  } al_sb_t;

  // table contents after reset: two white nodes at 0 and 1.0
  function automatic node_t reset_node(input logic [7:0] k);
    node_t nd;
    nd = '0;
    if (k < 8'd2) begin
      nd.color = {4{ONE_Q16}};
    end
    if (k == 8'd1) begin
      nd.pos = ONE_Q16;
    end
    return nd;
  endfunction

  function automatic logic [CH_W-1:0] chan(input color_t c, input logic [1:0] i);
    logic [4*CH_W-1:0] v;
    v = c;
    return v[(3 - i) * CH_W +: CH_W];
  endfunction

endpackage

/* rtl/plcr_if.sv */
// channel interfaces: texel/node input, texel result, configuration write
interface plcr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [plcr_pkg::NIDX_W-1:0]   node_index;
  logic [plcr_pkg::CH_W-1:0]     node_red;
  logic [plcr_pkg::CH_W-1:0]     node_green;
  logic [plcr_pkg::CH_W-1:0]     node_blue;
  logic [plcr_pkg::CH_W-1:0]     node_alpha;
  logic [plcr_pkg::Q_W-1:0]      node_position;
  logic [plcr_pkg::IDX_W-1:0]    texel_index;
  modport source(output valid, func, node_index, node_red, node_green, node_blue,
                 node_alpha, node_position, texel_index, input ready);
  modport sink(input valid, func, node_index, node_red, node_green, node_blue,
               node_alpha, node_position, texel_index, output ready);
endinterface

interface plcr_out_if;
  logic                      valid;
  logic                      ready;
  logic [plcr_pkg::CH_W-1:0] texel_red;
  logic [plcr_pkg::CH_W-1:0] texel_green;
  logic [plcr_pkg::CH_W-1:0] texel_blue;
  logic [plcr_pkg::CH_W-1:0] texel_alpha;
  logic                      empty_res;
  modport source(output valid, texel_red, texel_green, texel_blue, texel_alpha,
                 empty_res, input ready);
  modport sink(input valid, texel_red, texel_green, texel_blue, texel_alpha,
               empty_res, output ready);
endinterface

interface plcr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [plcr_pkg::CFG_IDX_W-1:0]  index;
  logic [plcr_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/plcr_div.sv */
// pipelined restoring divider, one quotient bit per stage
module plcr_div #(
  parameter int DW  = 17,
  parameter int QW  = 16,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  logic [DW-1:0]  in_rem,
  input  logic [QW-1:0]  in_num,
  input  logic [DW-1:0]  in_den,
  input  logic [SBW-1:0] in_sb,
  output logic           out_v,
  output logic [QW-1:0]  out_q,
  output logic [SBW-1:0] out_sb
);

  logic           v_r   [1:QW];
  logic [DW-1:0]  rem_r [1:QW];
  logic [QW-1:0]  num_r [1:QW];
  logic [QW-1:0]  q_r   [1:QW];
  logic [DW-1:0]  den_r [1:QW];
  logic [SBW-1:0] sb_r  [1:QW];

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic           p_v;
    logic [DW-1:0]  p_rem;
    logic [QW-1:0]  p_num;
    logic [QW-1:0]  p_q;
    logic [DW-1:0]  p_den;
    logic [SBW-1:0] p_sb;
    logic [DW:0]    trial;
    logic           ge;

    if (s == 1) begin : g_first
      assign p_v   = in_v;
      assign p_rem = in_rem;
      assign p_num = in_num;
      assign p_q   = '0;
      assign p_den = in_den;
      assign p_sb  = in_sb;
    end else begin : g_next
      assign p_v   = v_r[s-1];
      assign p_rem = rem_r[s-1];
      assign p_num = num_r[s-1];
      assign p_q   = q_r[s-1];
      assign p_den = den_r[s-1];
      assign p_sb  = sb_r[s-1];
    end

    assign trial = {p_rem, p_num[QW-1]};
    assign ge    = trial >= {1'b0, p_den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? DW'(trial - {1'b0, p_den}) : trial[DW-1:0];
        num_r[s] <= {p_num[QW-2:0], 1'b0};
        q_r[s]   <= {p_q[QW-2:0], ge};
        den_r[s] <= p_den;
        sb_r[s]  <= p_sb;
      end
    end
  end

  assign out_v  = v_r[QW];
  assign out_q  = q_r[QW];
  assign out_sb = sb_r[QW];

endmodule

/* rtl/plcr_ntab.sv */
// node storage, right-node search and registered reads of the two nodes
module plcr_ntab #(
  parameter int MAX_NODES = plcr_pkg::MAX_NODES_DEF,
  localparam int NW  = $clog2(MAX_NODES),
  localparam int NCW = $clog2(MAX_NODES + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        wr_en,
  input  logic [plcr_pkg::NIDX_W-1:0] wr_idx,
  input  plcr_pkg::node_t             wr_node,
  input  logic [NCW-1:0]              n_eff,
  input  logic                        lk_v,
  input  logic                        lk_empty,
  input  logic [plcr_pkg::Q_W-1:0]    lk_px,
  output logic                        s_v,
  output logic                        s_empty,
  output logic [plcr_pkg::Q_W-1:0]    s_px,
  output plcr_pkg::node_t             s_left,
  output plcr_pkg::node_t             s_right
);

  plcr_pkg::node_t            mem [MAX_NODES];
  logic [plcr_pkg::Q_W-1:0]   pos_r [MAX_NODES];
  logic [MAX_NODES-1:0]       vld_r;
  logic                       wr_ok;
  logic [NW-1:0]              wa;
  logic [NW-1:0]              r_idx;
  logic [NW-1:0]              l_idx;
  logic                       s_v_r;
  logic                       s_empty_r;
  logic [plcr_pkg::Q_W-1:0]   s_px_r;
  logic [NW-1:0]              l_r;
  logic [NW-1:0]              r_r;
  logic                       vl_r;
  logic                       vr_r;
  plcr_pkg::node_t            rdl_r;
  plcr_pkg::node_t            rdr_r;

  assign wr_ok = wr_en && (int'(wr_idx) < MAX_NODES);
  assign wa    = NW'(wr_idx);

  // first node in use past the texel position, else the last one in use
  always_comb begin
    r_idx = NW'(n_eff - 1'b1);
    for (int j = MAX_NODES - 1; j >= 0; j--) begin
      if ((NCW'(j) < n_eff) && (pos_r[j] > lk_px)) begin
        r_idx = NW'(j);
      end
    end
    l_idx = (r_idx != '0) ? NW'(r_idx - 1'b1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_NODES; k++) begin
        pos_r[k] <= plcr_pkg::reset_node(8'(k)).pos;
      end
      vld_r <= '0;
    end else if (wr_ok) begin
      pos_r[wa]  <= wr_node.pos;
      vld_r[wa]  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wa] <= wr_node;
    end
    if (en) begin
      rdl_r <= mem[l_idx];
      rdr_r <= mem[r_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (en) begin
      s_v_r <= lk_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_empty_r <= lk_empty;
      s_px_r    <= lk_px;
      l_r       <= l_idx;
      r_r       <= r_idx;
      vl_r      <= vld_r[l_idx];
      vr_r      <= vld_r[r_idx];
    end
  end

  assign s_v     = s_v_r;
  assign s_empty = s_empty_r;
  assign s_px    = s_px_r;
  assign s_left  = vl_r ? rdl_r : plcr_pkg::reset_node(8'(l_r));
  assign s_right = vr_r ? rdr_r : plcr_pkg::reset_node(8'(r_r));

endmodule

/* rtl/plcr_mix.sv */
// weight select, channel products, then sums and output register
module plcr_mix (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  plcr_pkg::al_sb_t            in_sb,
  input  logic [plcr_pkg::FRAC_W-1:0] in_q,
  output logic                        out_v,
  output plcr_pkg::color_t            out_color,
  output logic                        out_empty
);

  localparam int PW = 2 * plcr_pkg::CH_W;

  logic [plcr_pkg::Q_W-1:0]  al;
  logic [plcr_pkg::Q_W-1:0]  be;
  logic                      m1_v_r;
  logic                      m1_empty_r;
  logic [PW-1:0]             pl_r [4];
  logic [PW-1:0]             pr_r [4];
  logic [plcr_pkg::CH_W-1:0] ch_nxt [4];
  logic                      out_v_r;
  logic                      out_empty_r;
  plcr_pkg::color_t          out_color_r;

  always_comb begin
    priority if (in_sb.al_zero) begin
      al = '0;
    end else if (in_sb.al_one) begin
      al = plcr_pkg::ONE_Q16;
    end else begin
      al = {1'b0, in_q};
    end
    be = plcr_pkg::ONE_Q16 - al;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r  <= in_v;
      out_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_empty_r <= in_sb.empty;
      for (int i = 0; i < 4; i++) begin
        pl_r[i] <= plcr_pkg::chan(in_sb.left, 2'(i)) * be;
        pr_r[i] <= plcr_pkg::chan(in_sb.right, 2'(i)) * al;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [PW:0] sum;
      sum       = {1'b0, pl_r[i]} + {1'b0, pr_r[i]};
      ch_nxt[i] = m1_empty_r ? '0 : sum[plcr_pkg::FRAC_W +: plcr_pkg::CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_empty_r       <= m1_empty_r;
      out_color_r.red   <= ch_nxt[0];
      out_color_r.green <= ch_nxt[1];
      out_color_r.blue  <= ch_nxt[2];
      out_color_r.alpha <= ch_nxt[3];
    end
  end

  assign out_v     = out_v_r;
  assign out_color = out_color_r;
  assign out_empty = out_empty_r;

endmodule

/* rtl/piecewise_linear_color_ramp.sv */
// top level of the piecewise-linear rgba color ramp
//
//   channel  | direction | transaction
//   in_chan  | sink      | func 0: node write, func 1: texel request
//   out_chan | source    | one texel (or empty flag) per texel request
//   cfg_chan | sink      | register write: texture_size, used node count
//
// a texel request enters in any cycle in which the output is not stalled, before earlier
// results leave; its path holds the two bit-per-stage dividers (17 + 16 stages) plus 5 other stages
// reset (synchronous, rst_n low) restores two white nodes at 0 and 1.0,
// texture_size 256 and two nodes in use; the table needs no clearing pass
// a stalled output freezes the whole pipeline in place
// a node write waits until no texel transaction is in flight
// a register write also waits until no texel transaction is in flight
module piecewise_linear_color_ramp #(
  parameter int MAX_NODES = plcr_pkg::MAX_NODES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  plcr_in_if.sink   in_chan,
  plcr_out_if.source out_chan,
  plcr_cfg_if.sink  cfg_chan
);

  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int QW2 = plcr_pkg::FRAC_W;
  localparam int SBW = $bits(plcr_pkg::al_sb_t);

  // configuration registers
  logic [plcr_pkg::SIZE_W-1:0] texture_size_r;
  logic [plcr_pkg::CNT_W-1:0]  used_nodes_r;

  // pipeline control
  logic                            en;
  logic                            in_acc;
  logic                            rd_acc;
  logic                            out_acc;
  logic [plcr_pkg::INFLIGHT_W-1:0] inflight_r;
  logic [plcr_pkg::INFLIGHT_W-1:0] inflight_nxt;

  // effective settings
  logic [plcr_pkg::SIZE_W-1:0] size_eff;
  logic [NCW-1:0]              n_eff;
  logic                        empty_nxt;

  // request stage
  logic                        a_v_r;
  logic                        a_empty_r;
  logic [plcr_pkg::SIZE_W-1:0] a_rem_r;
  logic [plcr_pkg::Q_W-1:0]    a_num_r;
  logic [plcr_pkg::SIZE_W-1:0] a_den_r;

  // texel position divider
  logic                     d1_v;
  logic [plcr_pkg::Q_W-1:0] d1_px;
  logic                     d1_empty;

  // node lookup
  logic                     s_v;
  logic                     s_empty;
  logic [plcr_pkg::Q_W-1:0] s_px;
  plcr_pkg::node_t          s_left;
  plcr_pkg::node_t          s_right;
  plcr_pkg::node_t          wr_node;

  // weight setup stage
  logic                     gt;
  logic                     t_v_r;
  plcr_pkg::al_sb_t         t_sb_r;
  logic [plcr_pkg::Q_W-1:0] t_rem_r;
  logic [plcr_pkg::Q_W-1:0] t_den_r;
  plcr_pkg::al_sb_t         t_sb_nxt;

  // weight divider
  logic                     d2_v;
  logic [QW2-1:0]           d2_q;
  logic [SBW-1:0]           d2_sb;

  // result
  logic                     m_v;
  plcr_pkg::color_t         m_color;
  logic                     m_empty;

  // the whole pipeline moves unless a result waits to be taken
  assign en      = !m_v || out_chan.ready;
  assign in_chan.ready = en && ((in_chan.func == plcr_pkg::FUNC_TEXEL) || (inflight_r == '0));
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign rd_acc  = in_acc && (in_chan.func == plcr_pkg::FUNC_TEXEL);
  assign out_acc = m_v && out_chan.ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (rd_acc && !out_acc) begin
      inflight_nxt = inflight_r + 1'b1;
    end else if (out_acc && !rd_acc) begin
      inflight_nxt = inflight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // configuration writes, taken once no texel is in flight
  assign cfg_chan.ready = (inflight_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      texture_size_r <= plcr_pkg::SIZE_W'(256);
      used_nodes_r   <= plcr_pkg::CNT_W'(2);
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (plcr_pkg::cfg_reg_t'(cfg_chan.index))
        plcr_pkg::REG_TEXTURE_SIZE: begin
          texture_size_r <= cfg_chan.data[plcr_pkg::SIZE_W-1:0];
        end
        plcr_pkg::REG_USED_NODES: begin
          used_nodes_r <= cfg_chan.data[plcr_pkg::CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // clamp the settings to the table and texel limits
  assign size_eff = (int'(texture_size_r) > plcr_pkg::MAX_TEXELS) ?
                    plcr_pkg::SIZE_W'(plcr_pkg::MAX_TEXELS) : texture_size_r;
  assign n_eff    = (int'(used_nodes_r) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(used_nodes_r);
  assign empty_nxt = (used_nodes_r < plcr_pkg::CNT_W'(2)) || (size_eff == '0) ||
                     ({1'b0, in_chan.texel_index} >= size_eff);

  // request stage: set up index * 65536 / (size - 1)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= rd_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_empty_r <= empty_nxt;
      a_rem_r   <= plcr_pkg::SIZE_W'(in_chan.texel_index >> 1);
      a_num_r   <= {in_chan.texel_index[0], {plcr_pkg::FRAC_W{1'b0}}};
      // a one-texel ramp has index 0, so dividing by one gives position 0
      a_den_r   <= (size_eff > plcr_pkg::SIZE_W'(1)) ? plcr_pkg::SIZE_W'(size_eff - 1'b1)
                                                     : plcr_pkg::SIZE_W'(1);
    end
  end

  plcr_div #(
    .DW  (plcr_pkg::SIZE_W),
    .QW  (plcr_pkg::Q_W),
    .SBW (1)
  ) u_px_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (a_v_r),
    .in_rem (a_rem_r),
    .in_num (a_num_r),
    .in_den (a_den_r),
    .in_sb  (a_empty_r),
    .out_v  (d1_v),
    .out_q  (d1_px),
    .out_sb (d1_empty)
  );

  assign wr_node.color.red   = in_chan.node_red;
  assign wr_node.color.green = in_chan.node_green;
  assign wr_node.color.blue  = in_chan.node_blue;
  assign wr_node.color.alpha = in_chan.node_alpha;
  assign wr_node.pos         = in_chan.node_position;

  plcr_ntab #(
    .MAX_NODES (MAX_NODES)
  ) u_ntab (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .wr_en    (in_acc && (in_chan.func == plcr_pkg::FUNC_WRITE)),
    .wr_idx   (in_chan.node_index),
    .wr_node  (wr_node),
    .n_eff    (n_eff),
    .lk_v     (d1_v),
    .lk_empty (d1_empty),
    .lk_px    (d1_px),
    .s_v      (s_v),
    .s_empty  (s_empty),
    .s_px     (s_px),
    .s_left   (s_left),
    .s_right  (s_right)
  );

  // weight setup: zero weight gives the left color, also for equal positions
  assign gt = s_right.pos > s_left.pos;
  assign t_sb_nxt.empty   = s_empty;
  assign t_sb_nxt.al_zero = !gt || (s_px <= s_left.pos);
  assign t_sb_nxt.al_one  = s_px >= s_right.pos;
  assign t_sb_nxt.left    = s_left.color;
  assign t_sb_nxt.right   = s_right.color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
    end else if (en) begin
      t_v_r <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_sb_r  <= t_sb_nxt;
      t_rem_r <= (t_sb_nxt.al_zero || t_sb_nxt.al_one) ? '0 : plcr_pkg::Q_W'(s_px - s_left.pos);
      t_den_r <= gt ? plcr_pkg::Q_W'(s_right.pos - s_left.pos) : plcr_pkg::Q_W'(1);
    end
  end

  plcr_div #(
    .DW  (plcr_pkg::Q_W),
    .QW  (QW2),
    .SBW (SBW)
  ) u_al_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (t_v_r),
    .in_rem (t_rem_r),
    .in_num ('0),
    .in_den (t_den_r),
    .in_sb  (t_sb_r),
    .out_v  (d2_v),
    .out_q  (d2_q),
    .out_sb (d2_sb)
  );

  plcr_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (d2_v),
    .in_sb     (plcr_pkg::al_sb_t'(d2_sb)),
    .in_q      (d2_q),
    .out_v     (m_v),
    .out_color (m_color),
    .out_empty (m_empty)
  );

  assign out_chan.valid       = m_v;
  assign out_chan.texel_red   = m_color.red;
  assign out_chan.texel_green = m_color.green;
  assign out_chan.texel_blue  = m_color.blue;
  assign out_chan.texel_alpha = m_color.alpha;
  assign out_chan.empty_res   = m_empty;

endmodule

/* rtl/plcr_checker.sv */
// port checker for the color ramp and its bind
module plcr_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [plcr_pkg::CH_W-1:0] texel_red,
  input logic [plcr_pkg::CH_W-1:0] texel_green,
  input logic [plcr_pkg::CH_W-1:0] texel_blue,
  input logic [plcr_pkg::CH_W-1:0] texel_alpha,
  input logic                      empty_res
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(texel_red) && $stable(texel_green) &&
      $stable(texel_blue) && $stable(texel_alpha) && $stable(empty_res))
    else $error("result changed while stalled");

  // empty texels carry zero color
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && empty_res |-> texel_red == '0 && texel_green == '0 &&
      texel_blue == '0 && texel_alpha == '0)
    else $error("empty texel with nonzero color");

  // reset leaves no result behind
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind piecewise_linear_color_ramp plcr_checker u_plcr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .texel_red   (out_chan.texel_red),
  .texel_green (out_chan.texel_green),
  .texel_blue  (out_chan.texel_blue),
  .texel_alpha (out_chan.texel_alpha),
  .empty_res   (out_chan.empty_res)
);
